>>> rtl/dpbd_pkg.sv
// ----------------------------------------------------------------------------
// dpbd_pkg
// Shared types and constants for the pulse bit demodulator.
// ----------------------------------------------------------------------------
package dpbd_pkg;

   localparam int PERIOD_MS_DEF     = 1000;
   localparam int FILTER_WEIGHT_DEF = 30;
   localparam int TIME_W            = 32;
   localparam int CSR_ADDR_W        = 5;
   localparam int CSR_DATA_W        = 32;

   localparam logic [10:0] PULSE_MIN_GAP_RST  = 11'd700;
   localparam logic [9:0]  EARLY_WINDOW_RST   = 10'd50;
   localparam logic [9:0]  LATE_WINDOW_RST    = 10'd200;
   localparam logic [10:0] LONG_LOW_MIN_RST   = 11'd500;
   localparam logic [9:0]  ZERO_THRESHOLD_RST = 10'd850;
   localparam logic [11:0] MINUTE_GAP_RST     = 12'd1500;

   typedef struct packed {
      logic [10:0] pulse_min_gap;
      logic [9:0]  early_window;
      logic [9:0]  late_window;
      logic [10:0] long_low_min;
      logic [9:0]  zero_threshold;
      logic [11:0] minute_gap;
   } cfg_type;

   typedef struct packed {
      logic              level;
      logic [TIME_W-1:0] time_ms;
   } event_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [2:0] {
      CSR_PULSE_MIN_GAP,
      CSR_EARLY_WINDOW,
      CSR_LATE_WINDOW,
      CSR_LONG_LOW_MIN,
      CSR_ZERO_THRESHOLD,
      CSR_MINUTE_GAP
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ALIGN,
      ST_AL_WAIT,
      ST_FILT,
      ST_F_MUL,
      ST_F_DIV,
      ST_F_WAIT,
      ST_WINDOW,
      ST_PASS,
      ST_BIT
   } back_state_type;

endpackage

>>> rtl/dpbd_if.sv
// ----------------------------------------------------------------------------
// dpbd_if
// Sample and bit channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dpbd_req_if;
   logic        valid;
   logic        ready;
   logic        level;
   logic [31:0] time_ms;

   modport source (output valid, output level, output time_ms, input ready);
   modport sink   (input valid, input level, input time_ms, output ready);
endinterface

interface dpbd_rsp_if;
   logic valid;
   logic ready;
   logic bit_value;
   logic frame_end;

   modport source (output valid, output bit_value, output frame_end, input ready);
   modport sink   (input valid, input bit_value, input frame_end, output ready);
endinterface

>>> rtl/dpbd_fifo.sv
// ----------------------------------------------------------------------------
// dpbd_fifo
// Two-entry event queue between the front and back parts.
// ----------------------------------------------------------------------------
module dpbd_fifo
   import dpbd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type din,
   input  logic      pop,
   output event_type dout,
   output logic      empty,
   output logic      full
);

   event_type  mem_ff [2];
   event_type  mem_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign dout  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         mem_in[wr_ptr_ff] = din;
         wr_ptr_in         = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/dpbd_front.sv
// ----------------------------------------------------------------------------
// dpbd_front
// Accepts samples, drops repeated timestamps and non-edges, queues edges.
// ----------------------------------------------------------------------------
module dpbd_front
   import dpbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dpbd_req_if.sink   req_chan,
   input  logic       q_full,
   output logic       q_push,
   output event_type  q_din
);

   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic              seen_ff, seen_in;
   logic              accept;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   always_comb begin
      last_time_in  = last_time_ff;
      seen_in       = seen_ff;
      q_push        = 1'b0;
      q_din.level   = req_chan.level;
      q_din.time_ms = req_chan.time_ms;
      if (accept && (req_chan.time_ms != last_time_ff)) begin
         last_time_in = req_chan.time_ms;
         if (req_chan.level != seen_ff) begin
            seen_in = ~seen_ff;
            q_push  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         seen_ff      <= 1'b0;
      end else begin
         last_time_ff <= last_time_in;
         seen_ff      <= seen_in;
      end
   end

endmodule

>>> rtl/dpbd_div.sv
// ----------------------------------------------------------------------------
// dpbd_div
// Constant divider by reciprocal multiplication, 32-bit dividend, multiply, quotient and remainder steps.
// ----------------------------------------------------------------------------
module dpbd_div
   import dpbd_pkg::*;
#(
   parameter int DVW   = 10,
   parameter int DIV_A = PERIOD_MS_DEF,
   parameter int DIV_B = FILTER_WEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              use_b,
   input  logic [TIME_W-1:0] dividend,
   output div_stat_type      stat,
   output logic [TIME_W-1:0] quotient,
   output logic [DVW-1:0]    remainder
);

   localparam int PW   = 2 * TIME_W + 1;
   localparam int SH_A = TIME_W + $clog2(DIV_A);
   localparam int SH_B = TIME_W + $clog2(DIV_B);
   // rounded-up reciprocals, exact for any 32-bit dividend
   localparam logic [63:0] RCP_A_W = ((64'd1 << SH_A) + 64'(DIV_A) - 64'd1) / 64'(DIV_A);
   localparam logic [63:0] RCP_B_W = ((64'd1 << SH_B) + 64'(DIV_B) - 64'd1) / 64'(DIV_B);
   localparam logic [TIME_W:0]   RCP_A = RCP_A_W[TIME_W:0];
   localparam logic [TIME_W:0]   RCP_B = RCP_B_W[TIME_W:0];
   localparam logic [TIME_W-1:0] D_A   = TIME_W'(DIV_A);
   localparam logic [TIME_W-1:0] D_B   = TIME_W'(DIV_B);

   logic [TIME_W-1:0] x_ff, x_in;
   logic              sel_ff, sel_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [TIME_W-1:0] q_ff, q_in;
   logic [DVW-1:0]    r_ff, r_in;
   logic [1:0]        ph_ff, ph_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      x_in    = x_ff;
      sel_in  = sel_ff;
      prod_in = prod_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      ph_in   = ph_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = dividend;
         sel_in  = use_b;
         ph_in   = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (ph_ff)
            2'd0: begin
               prod_in = PW'(x_ff) * PW'(sel_ff ? RCP_B : RCP_A);
               ph_in   = 2'd1;
            end
            2'd1: begin
               q_in  = sel_ff ? TIME_W'(prod_ff >> SH_B) : TIME_W'(prod_ff >> SH_A);
               ph_in = 2'd2;
            end
            default: begin
               r_in    = DVW'(x_ff - q_ff * (sel_ff ? D_B : D_A));
               ph_in   = 2'd0;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      sel_ff  <= sel_in;
      prod_ff <= prod_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      ph_ff   <= ph_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

>>> rtl/dpbd_back.sv
// ----------------------------------------------------------------------------
// dpbd_back
// Phase tracking, edge window check and bit decision for queued edges.
// ----------------------------------------------------------------------------
module dpbd_back
   import dpbd_pkg::*;
#(
   parameter int PERIOD_MS     = PERIOD_MS_DEF,
   parameter int FILTER_WEIGHT = FILTER_WEIGHT_DEF,
   parameter int DVW           = 10,
   parameter int WW            = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  event_type  q_dout,
   input  logic       q_empty,
   output logic       q_pop,
   dpbd_rsp_if.source rsp_chan
);

   localparam logic [TIME_W-1:0] PERIOD_T = TIME_W'(PERIOD_MS);
   localparam logic [TIME_W-1:0] HALF_T   = TIME_W'(PERIOD_MS / 2);
   localparam logic [DVW-1:0]    PERIOD_D = DVW'(PERIOD_MS);
   localparam logic [WW-1:0]     WM1      = WW'(FILTER_WEIGHT - 1);

   back_state_type    state_ff, state_in;
   back_state_type    ret_ff, ret_in;
   event_type         ev_ff, ev_in;
   logic [TIME_W-1:0] at_ff, at_in;
   logic [TIME_W-1:0] ref_ff, ref_in;
   logic [TIME_W-1:0] lpe_ff, lpe_in;
   logic [TIME_W-1:0] low_start_ff, low_start_in;
   logic              passed_ff, passed_in;
   logic              sign_ff, sign_in;
   logic              sel_ff, sel_in;
   logic [DVW-1:0]    g_ff, g_in;
   logic [DVW+WW-1:0] prod_ff, prod_in;
   logic              fe_ff, fe_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_bit_ff, rsp_bit_in;
   logic              rsp_fe_ff, rsp_fe_in;

   logic [TIME_W-1:0] behind, ahead, al_div, gap_t, low_len, lead;
   logic              al_small, reject, out_free;
   logic              div_start;
   logic [TIME_W-1:0] div_dividend;
   logic              div_use_wt;
   div_stat_type      div_stat;
   logic [TIME_W-1:0] div_quot;
   logic [DVW-1:0]    div_rem;

   // offset that moves the reference into [at, at + period - 1]
   function automatic logic [DVW-1:0] align_off(input logic [DVW-1:0] r, input logic neg);
      logic [DVW-1:0] o;
      if (neg) begin
         o = r;
      end else if (r != '0) begin
         o = PERIOD_D - r;
      end else begin
         o = '0;
      end
      return o;
   endfunction

   dpbd_div #(
      .DVW   (DVW),
      .DIV_A (PERIOD_MS),
      .DIV_B (FILTER_WEIGHT)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .use_b     (div_use_wt),
      .dividend  (div_dividend),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign behind   = at_ff - ref_ff;
   assign ahead    = ref_ff - at_ff;
   assign al_div   = behind[TIME_W-1] ? ahead : behind;
   assign al_small = (al_div < PERIOD_T);
   assign gap_t    = ref_ff - ev_ff.time_ms;
   assign low_len  = ev_ff.time_ms - low_start_ff;
   assign lead     = ref_ff - low_start_ff;
   assign reject   = (gap_t > TIME_W'(cfg.early_window)) &&
                     ((gap_t + TIME_W'(cfg.late_window)) < PERIOD_T);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ev_ff.level ? ST_ALIGN : ST_IDLE;
         end
         ST_ALIGN: begin
            if ((behind == '0) || al_small) state_in = ret_ff;
            else state_in = ST_AL_WAIT;
         end
         ST_AL_WAIT: begin
            if (div_stat.done) state_in = ret_ff;
         end
         ST_FILT: begin
            state_in = (gap_t == '0) ? ST_ALIGN : ST_F_MUL;
         end
         ST_F_MUL:  state_in = ST_F_DIV;
         ST_F_DIV:  state_in = ST_F_WAIT;
         ST_F_WAIT: begin
            if (div_stat.done) state_in = ST_ALIGN;
         end
         ST_WINDOW: begin
            state_in = reject ? ST_IDLE : ST_PASS;
         end
         ST_PASS: begin
            if (passed_ff || (low_len <= TIME_W'(cfg.long_low_min))) state_in = ST_IDLE;
            else state_in = ST_ALIGN;
         end
         ST_BIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ret_in       = ret_ff;
      ev_in        = ev_ff;
      at_in        = at_ff;
      ref_in       = ref_ff;
      lpe_in       = lpe_ff;
      low_start_in = low_start_ff;
      passed_in    = passed_ff;
      sign_in      = sign_ff;
      sel_in       = sel_ff;
      g_in         = g_ff;
      prod_in      = prod_ff;
      fe_in        = fe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_bit_in   = rsp_bit_ff;
      rsp_fe_in    = rsp_fe_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = al_div;
      div_use_wt   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               ev_in = q_dout;
            end
         end
         ST_DECODE: begin
            if (ev_ff.level) begin
               at_in = ev_ff.time_ms;
               if ((ev_ff.time_ms - lpe_ff) > TIME_W'(cfg.pulse_min_gap)) begin
                  lpe_in = ev_ff.time_ms;
                  ret_in = ST_FILT;
               end else begin
                  ret_in = ST_WINDOW;
               end
            end else if (passed_ff) begin
               passed_in    = 1'b0;
               low_start_in = ev_ff.time_ms;
            end
         end
         ST_ALIGN: begin
            sign_in = behind[TIME_W-1];
            if (behind != '0) begin
               if (al_small) begin
                  ref_in = at_ff + TIME_W'(align_off(al_div[DVW-1:0], behind[TIME_W-1]));
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_AL_WAIT: begin
            if (div_stat.done) begin
               ref_in = at_ff + TIME_W'(align_off(div_rem, sign_ff));
            end
         end
         ST_FILT: begin
            // reference now lies less than a period ahead of the edge
            sel_in = (gap_t < HALF_T);
            g_in   = (gap_t < HALF_T) ? gap_t[DVW-1:0] : (PERIOD_D - gap_t[DVW-1:0]);
            ret_in = ST_WINDOW;
         end
         ST_F_MUL: begin
            prod_in = g_ff * WM1;
         end
         ST_F_DIV: begin
            div_start    = 1'b1;
            div_dividend = TIME_W'(prod_ff);
            div_use_wt   = 1'b1;
         end
         ST_F_WAIT: begin
            div_dividend = TIME_W'(prod_ff);
            div_use_wt   = 1'b1;
            if (div_stat.done) begin
               ref_in = sel_ff ? (ev_ff.time_ms + div_quot)
                               : (ev_ff.time_ms + PERIOD_T - div_quot);
            end
         end
         ST_WINDOW: begin
         end
         ST_PASS: begin
            if (!passed_ff) begin
               passed_in = 1'b1;
               if (low_len > TIME_W'(cfg.long_low_min)) begin
                  fe_in  = (low_len > TIME_W'(cfg.minute_gap));
                  at_in  = low_start_ff;
                  ret_in = ST_BIT;
               end
            end
         end
         ST_BIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = !(lead > TIME_W'(cfg.zero_threshold));
               rsp_fe_in    = fe_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      ev_ff      <= ev_in;
      at_ff      <= at_in;
      sign_ff    <= sign_in;
      sel_ff     <= sel_in;
      g_ff       <= g_in;
      prod_ff    <= prod_in;
      fe_ff      <= fe_in;
      rsp_bit_ff <= rsp_bit_in;
      rsp_fe_ff  <= rsp_fe_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         ref_ff       <= '0;
         lpe_ff       <= '0;
         low_start_ff <= '0;
         passed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_ff       <= ref_in;
         lpe_ff       <= lpe_in;
         low_start_ff <= low_start_in;
         passed_ff    <= passed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.bit_value = rsp_bit_ff;
   assign rsp_chan.frame_end = rsp_fe_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_pass_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(passed_ff) |-> $past(state_ff == ST_PASS))
      else $error("passed level set outside pass step");

   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_BIT))
      else $error("result raised outside bit step");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule

>>> rtl/dcf77_pulse_bit_demodulator.sv
// ----------------------------------------------------------------------------
// dcf77_pulse_bit_demodulator
// Receiver edge filter, 1 Hz phase tracker and pulse-length bit decoder.
// ----------------------------------------------------------------------------
// path: an accepted edge is queued, then the back sequencer decodes it, aligns
//   the reference (via the reciprocal remainder unit when a period or more
//   off), may run the filter step, checks the window and decides the bit,
//   waiting for room on the output; the back handles one edge at a time.
// throughput: the front takes a sample per cycle while the 2-entry queue has room.
// reset: synchronous; clears all tracking state and loads register defaults.
module dcf77_pulse_bit_demodulator
   import dpbd_pkg::*;
#(
   parameter int PERIOD_MS     = PERIOD_MS_DEF,
   parameter int FILTER_WEIGHT = FILTER_WEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   dpbd_req_if.sink              req_chan,
   dpbd_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int PW  = $clog2(PERIOD_MS + 1);
   localparam int FW  = $clog2(FILTER_WEIGHT + 1);
   localparam int DVW = (PW > FW) ? PW : FW;
   localparam int WW  = $clog2(FILTER_WEIGHT);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_idx;
   logic          csr_wr;
   event_type     q_din, q_dout;
   logic          q_push, q_pop, q_empty, q_full;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_PULSE_MIN_GAP:  cfg_in.pulse_min_gap  = pwdata[10:0];
            CSR_EARLY_WINDOW:   cfg_in.early_window   = pwdata[9:0];
            CSR_LATE_WINDOW:    cfg_in.late_window    = pwdata[9:0];
            CSR_LONG_LOW_MIN:   cfg_in.long_low_min   = pwdata[10:0];
            CSR_ZERO_THRESHOLD: cfg_in.zero_threshold = pwdata[9:0];
            CSR_MINUTE_GAP:     cfg_in.minute_gap     = pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_PULSE_MIN_GAP:  prdata = CSR_DATA_W'(cfg_ff.pulse_min_gap);
         CSR_EARLY_WINDOW:   prdata = CSR_DATA_W'(cfg_ff.early_window);
         CSR_LATE_WINDOW:    prdata = CSR_DATA_W'(cfg_ff.late_window);
         CSR_LONG_LOW_MIN:   prdata = CSR_DATA_W'(cfg_ff.long_low_min);
         CSR_ZERO_THRESHOLD: prdata = CSR_DATA_W'(cfg_ff.zero_threshold);
         CSR_MINUTE_GAP:     prdata = CSR_DATA_W'(cfg_ff.minute_gap);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min_gap  <= PULSE_MIN_GAP_RST;
         cfg_ff.early_window   <= EARLY_WINDOW_RST;
         cfg_ff.late_window    <= LATE_WINDOW_RST;
         cfg_ff.long_low_min   <= LONG_LOW_MIN_RST;
         cfg_ff.zero_threshold <= ZERO_THRESHOLD_RST;
         cfg_ff.minute_gap     <= MINUTE_GAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dpbd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_din    (q_din)
   );

   dpbd_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty),
      .full  (q_full)
   );

   dpbd_back #(
      .PERIOD_MS     (PERIOD_MS),
      .FILTER_WEIGHT (FILTER_WEIGHT),
      .DVW           (DVW),
      .WW            (WW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_dout   (q_dout),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
